[hw/rtl/overwrite_oldest_record_ring_defines.svh]
// Assertion macros for the record ring
`ifndef OVERWRITE_OLDEST_RECORD_RING_DEFINES_SVH
`define OVERWRITE_OLDEST_RECORD_RING_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define OORR_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);
// next-cycle implication checked outside reset
`define OORR_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`endif

[hw/rtl/oorr_pkg.sv]
// Shared types and constants of the record ring
package oorr_pkg;
  localparam int BUFFER_BYTES = 1024;
  localparam int HEADER_BYTES = 5;
  localparam int SIZE_FIELD_OFFSET = 3;
  localparam int PW = $clog2(BUFFER_BYTES);

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_NEXT  = 2'd2;
  localparam logic [1:0] ACT_COMMIT = 2'd3;

  // classified command from front end to back end
  typedef struct packed {
    logic [1:0]  act;
    logic [7:0]  data;
    logic        first;
    logic [9:0]  len;
    logic [9:0]  offset;
  } cmd_t;

  // one result word
  typedef struct packed {
    logic [7:0] rbyte;
    logic [9:0] occ;
    logic       empty;
    logic [7:0] dropped;
    logic       status;
  } res_t;
endpackage

[hw/rtl/oorr_front.sv]
// Front end: two-entry command queue that accepts input words
module oorr_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  oorr_pkg::cmd_t cmd_in,
  output logic           cmd_valid,
  input  logic           cmd_take,
  output oorr_pkg::cmd_t cmd_out
);
  oorr_pkg::cmd_t q [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] count;
  logic do_push, do_pop;

  assign full = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd_out = q[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = cmd_take && cmd_valid;

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) q[wr_ptr] <= cmd_in;
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule

[hw/rtl/oorr_back.sv]
// Back end: sequencer over the byte memory and the result register
`include "overwrite_oldest_record_ring_defines.svh"
module oorr_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_take,
  input  oorr_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_take,
  output oorr_pkg::res_t res
);
  localparam int PW = oorr_pkg::PW;
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDLO = 3'd1;
  localparam logic [2:0] S_RDHI = 3'd2;
  localparam logic [2:0] S_DROP = 3'd3;
  localparam logic [2:0] S_RDB  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;
  localparam logic [2:0] S_RDW  = 3'd6;
  localparam logic [PW-1:0] CAP = PW'(oorr_pkg::BUFFER_BYTES - 1);

  logic [7:0] mem [oorr_pkg::BUFFER_BYTES];
  logic [7:0] rdata;
  logic [PW-1:0] raddr;
  logic mwe;
  logic [PW-1:0] waddr;
  logic [7:0] wdata;

  logic [2:0] state;
  logic [PW-1:0] rp, wp, tp;
  logic [9:0] left;
  logic rej;
  oorr_pkg::cmd_t c;
  logic [7:0] lo, dropped;
  logic [7:0] rbyte;
  logic st;
  logic [PW-1:0] held;
  logic [16:0] rec;
  logic long_len;
  logic fits;
  logic drop_all;

  assign held = wp - rp;
  // size field: low byte captured earlier, high byte on the read port now
  assign rec = {1'b0, rdata, lo} + 17'(oorr_pkg::HEADER_BYTES);
  assign long_len = ({{(32-10){1'b0}}, c.len} > 32'(oorr_pkg::BUFFER_BYTES - 1));
  assign fits = ({{(32-PW){1'b0}}, CAP - held} >= {22'd0, c.len});
  assign drop_all = ({15'd0, rec} >= {{(32-PW){1'b0}}, held});
  assign waddr = wp;
  assign wdata = c.data;

  // memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mwe) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // next word may be taken in the cycle the waiting result is popped
  assign cmd_take = (state == S_IDLE) && (!res_valid || res_take);

  // memory read address
  always_comb begin
    case (state)
      S_RDLO: raddr = rp + PW'(oorr_pkg::SIZE_FIELD_OFFSET + 1);
      S_RDB: raddr = tp;
      default: raddr = rp + PW'(oorr_pkg::SIZE_FIELD_OFFSET);
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rp <= '0;
      wp <= '0;
      tp <= '0;
      left <= '0;
      rej <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_take) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_valid && cmd_take) begin
            c <= cmd;
            dropped <= '0;
            rbyte <= '0;
            st <= 1'b0;
            state <= S_DONE;
            case (cmd.act)
              oorr_pkg::ACT_WRITE: begin
                if (cmd.first && cmd.len != 10'd0
                    && !({{(32-10){1'b0}}, cmd.len} > 32'(oorr_pkg::BUFFER_BYTES - 1)))
                  state <= S_DROP;
              end
              oorr_pkg::ACT_NEXT: state <= S_RDB;
              default: ;
            endcase
          end
        end
        S_DROP: begin
          // room for the record: store its first byte; else fetch the oldest header
          if (fits) begin
            wp <= wp + PW'(1);
            left <= c.len - 10'd1;
            rej <= 1'b0;
            state <= S_DONE;
          end else begin
            state <= S_RDLO;
          end
        end
        S_RDLO: begin
          lo <= rdata;
          state <= S_RDHI;
        end
        S_RDHI: begin
          // drop the oldest record; a broken size field empties the ring
          if (drop_all) begin
            rp <= wp;
            tp <= wp;
          end else begin
            rp <= rp + PW'(rec);
            tp <= rp + PW'(rec);
          end
          if (dropped != 8'hFF) dropped <= dropped + 8'd1;
          state <= S_DROP;
        end
        S_RDB: state <= S_RDW;
        S_RDW: begin
          rbyte <= rdata;
          tp <= tp + PW'(1);
          state <= S_DONE;
        end
        S_DONE: begin
          // simple actions then publish the result
          case (c.act)
            oorr_pkg::ACT_WRITE: begin
              if (c.first) begin
                if (long_len) begin
                  rej <= 1'b1;
                  left <= '0;
                  st <= 1'b1;
                end else if (c.len == 10'd0) begin
                  rej <= 1'b0;
                  left <= '0;
                end
              end else if (rej) begin
                st <= 1'b1;
              end else if (left != 10'd0) begin
                if (held != CAP) wp <= wp + PW'(1);
                left <= left - 10'd1;
              end
            end
            oorr_pkg::ACT_START: tp <= rp + PW'(c.offset);
            oorr_pkg::ACT_COMMIT: rp <= tp;
            default: ;
          endcase
          state <= S_IDLE;
          res_valid <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // write enable: first byte in the drop step, continuation bytes in the done step
  always_comb begin
    if (state == S_DROP && fits) mwe = 1'b1;
    else if (state == S_DONE && c.act == oorr_pkg::ACT_WRITE && !c.first && !rej
             && left != 10'd0 && held != CAP) mwe = 1'b1;
    else mwe = 1'b0;
  end

  assign res.rbyte = rbyte;
  assign res.occ = 10'(wp - rp);
  assign res.empty = (wp == rp);
  assign res.dropped = dropped;
  assign res.status = st;

  `OORR_ASSERT_IMP(a_take_idle, cmd_take, state == S_IDLE && (!res_valid || res_take),
    "command taken outside idle")
  `OORR_ASSERT_NEXT(a_res_hold, res_valid && !res_take, res_valid,
    "result dropped before taken")
  `OORR_ASSERT_IMP(a_no_take_busy, res_valid && !res_take, !cmd_take,
    "new command while result waits")
endmodule

[hw/rtl/overwrite_oldest_record_ring.sv]
// Top level of the overwrite-oldest record ring
// Usage:
//   Input side is a queue: drive action, data_byte, first_of_record,
//   record_length and read_offset with push; a word is taken when push
//   is high and full is low. Up to two words are buffered ahead of the
//   executing engine.
//   Result side is a queue: while empty is low the result word is on
//   read_byte, occupancy, is_empty, records_dropped and status; pop with
//   empty low takes it. One result word per input word, in order.
// Sequencing (from the accepting edge, engine idle):
//   Commit, start-read and plain byte writes go from idle straight to
//   the done state; a read-next passes the read and read-wait states
//   (registered memory read). A first byte passes the drop state, and
//   each dropped record adds the two header byte reads through the
//   single memory read port and a return to the drop state. The engine
//   takes the next word in the cycle its result is popped, one at a time.
// Reset: synchronous rst clears the pointers, record state and queues;
//   the byte memory is not cleared.
// Stall: while pop is held off the result waits and the engine stops;
//   the input queue fills and then raises full.
module overwrite_oldest_record_ring (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] action,
  input  logic [7:0] data_byte,
  input  logic       first_of_record,
  input  logic [9:0] record_length,
  input  logic [9:0] read_offset,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] read_byte,
  output logic [9:0] occupancy,
  output logic       is_empty,
  output logic [7:0] records_dropped,
  output logic       status
);
  oorr_pkg::cmd_t cmd_in, cmd;
  oorr_pkg::res_t res;
  logic cmd_valid, cmd_take, res_valid;

  assign cmd_in = '{act: action, data: data_byte, first: first_of_record,
                    len: record_length, offset: read_offset};

  oorr_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .cmd_in(cmd_in),
    .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd_out(cmd)
  );

  oorr_back u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
    .res_valid(res_valid), .res_take(pop), .res(res)
  );

  assign empty = !res_valid;
  assign read_byte = res.rbyte;
  assign occupancy = res.occ;
  assign is_empty = res.empty;
  assign records_dropped = res.dropped;
  assign status = res.status;
endmodule

[sim/testbench.sv]
// Testbench for the overwrite-oldest record ring: directed table, random records, predictor
`timescale 1ns / 100ps
module testbench;

  // one input word and one result word as seen at the ports
  typedef struct {
    logic [1:0] act;
    logic [7:0] data;
    logic       first;
    logic [9:0] len;
    logic [9:0] offset;
  } word_t;

  typedef struct {
    logic [7:0] rbyte;
    logic [9:0] occ;
    logic       empty;
    logic [7:0] dropped;
    logic       status;
  } outcome_t;

  // shadow copy of the ring
  typedef struct {
    logic [7:0] mem [oorr_pkg::BUFFER_BYTES];
    bit         written [oorr_pkg::BUFFER_BYTES];
    logic [9:0] rd_ptr;
    logic [9:0] wr_ptr;
    logic [9:0] tent_ptr;
    logic [9:0] left;
    bit         rejected;
  } ring_t;

  // directed table row
  typedef struct {
    word_t    w;
    bit       known;
    outcome_t e;
  } row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [1:0] action = oorr_pkg::ACT_COMMIT;
  logic [7:0] data_byte = '0;
  logic       first_of_record = 1'b0;
  logic [9:0] record_length = '0;
  logic [9:0] read_offset = '0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] read_byte;
  logic [9:0] occupancy;
  logic       is_empty;
  logic [7:0] records_dropped;
  logic       status;

  ring_t    ring;
  outcome_t pending_results [$];
  row_t     rows [$];
  int       mismatches = 0;
  int       cycles = 0;
  bit       no_idle = 1'b0;

  overwrite_oldest_record_ring dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .action(action),
    .data_byte(data_byte), .first_of_record(first_of_record),
    .record_length(record_length), .read_offset(read_offset), .empty(empty),
    .pop(pop), .read_byte(read_byte), .occupancy(occupancy), .is_empty(is_empty),
    .records_dropped(records_dropped), .status(status)
  );

  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("** overwrite_oldest_record_ring: FAILED **");
      $finish;
    end
  end

  // predict one word; flags any read of a byte never written
  function automatic void ring_step(inout ring_t s, input word_t w, output outcome_t e,
                                    output bit unsafe);
    int         held;
    int         rec;
    logic [9:0] a;
    e = '{rbyte: 8'd0, occ: 10'd0, empty: 1'b0, dropped: 8'd0, status: 1'b0};
    unsafe = 1'b0;
    case (w.act)
      oorr_pkg::ACT_WRITE: begin
        if (w.first) begin
          if (w.len > oorr_pkg::BUFFER_BYTES - 1) begin
            s.rejected = 1'b1;
            s.left = '0;
            e.status = 1'b1;
          end else if (w.len == 0) begin
            s.rejected = 1'b0;
            s.left = '0;
          end else begin
            s.rejected = 1'b0;
            held = int'(10'(s.wr_ptr - s.rd_ptr));
            while (oorr_pkg::BUFFER_BYTES - 1 - held < int'(w.len)) begin
              a = s.rd_ptr + 10'(oorr_pkg::SIZE_FIELD_OFFSET);
              if (!s.written[a] || !s.written[10'(a + 1)]) unsafe = 1'b1;
              rec = int'({s.mem[10'(a + 1)], s.mem[a]}) + oorr_pkg::HEADER_BYTES;
              if (rec >= held) s.rd_ptr = s.wr_ptr;
              else s.rd_ptr = s.rd_ptr + 10'(rec);
              s.tent_ptr = s.rd_ptr;
              if (e.dropped != 8'd255) e.dropped++;
              held = int'(10'(s.wr_ptr - s.rd_ptr));
            end
            s.mem[s.wr_ptr] = w.data;
            s.written[s.wr_ptr] = 1'b1;
            s.wr_ptr++;
            s.left = w.len - 10'd1;
          end
        end else if (s.rejected) begin
          e.status = 1'b1;
        end else if (s.left != 0) begin
          // a full ring discards the byte but still counts it
          if (10'(s.wr_ptr - s.rd_ptr) != 10'(oorr_pkg::BUFFER_BYTES - 1)) begin
            s.mem[s.wr_ptr] = w.data;
            s.written[s.wr_ptr] = 1'b1;
            s.wr_ptr++;
          end
          s.left--;
        end
      end
      oorr_pkg::ACT_START: s.tent_ptr = s.rd_ptr + w.offset;
      oorr_pkg::ACT_NEXT: begin
        if (!s.written[s.tent_ptr]) unsafe = 1'b1;
        e.rbyte = s.mem[s.tent_ptr];
        s.tent_ptr++;
      end
      default: s.rd_ptr = s.tent_ptr;
    endcase
    e.occ = s.wr_ptr - s.rd_ptr;
    e.empty = (s.rd_ptr == s.wr_ptr);
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // check result words as they are popped
  always @(posedge clk) begin
    outcome_t e;
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        report("unexpected word", 32'd0, 32'd0);
      end else begin
        e = pending_results.pop_front();
        if (read_byte !== e.rbyte) report("read_byte", 32'(read_byte), 32'(e.rbyte));
        if (occupancy !== e.occ) report("occupancy", 32'(occupancy), 32'(e.occ));
        if (is_empty !== e.empty) report("is_empty", 32'(is_empty), 32'(e.empty));
        if (records_dropped !== e.dropped)
          report("records_dropped", 32'(records_dropped), 32'(e.dropped));
        if (status !== e.status) report("status", 32'(status), 32'(e.status));
      end
    end
  end

  // receiver: random pops, one long hold-off to fill the block
  initial begin
    int k;
    int hold;
    bit held_off = 1'b0;
    @(negedge clk);
    while (1) begin
      if (!held_off && cycles > 1000) begin
        held_off = 1'b1;
        pop <= 1'b0;
        hold = 0;
        while (hold < 500) begin
          @(negedge clk);
          hold++;
        end
      end
      k = $urandom_range(0, 99);
      if (no_idle || k < 55) begin
        pop <= 1'b1;
        @(negedge clk);
      end else begin
        pop <= 1'b0;
        repeat (k < 92 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(negedge clk);
      end
    end
  end

  // drive one word and record its expectation at acceptance
  task automatic send(input word_t w, input outcome_t e);
    int k;
    push <= 1'b1;
    action <= w.act;
    data_byte <= w.data;
    first_of_record <= w.first;
    record_length <= w.len;
    read_offset <= w.offset;
    @(posedge clk);
    while (full) @(posedge clk);
    pending_results.push_back(e);
    @(negedge clk);
    k = $urandom_range(0, 99);
    if (!no_idle && k >= 60) begin
      push <= 1'b0;
      repeat (k < 92 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(negedge clk);
    end
  endtask

  task automatic add_row(input logic [1:0] act, input logic [7:0] data, input logic first,
                         input logic [9:0] len, input logic [9:0] offset, input bit known,
                         input logic [7:0] rb, input logic [9:0] occ, input logic emp);
    row_t r;
    r.w = '{act: act, data: data, first: first, len: len, offset: offset};
    r.known = known;
    r.e = '{rbyte: rb, occ: occ, empty: emp, dropped: 8'd0, status: 1'b0};
    rows.push_back(r);
  endtask

  function automatic word_t any_word();
    word_t w;
    w.act = 2'($urandom);
    w.data = 8'($urandom);
    w.first = 1'($urandom);
    w.len = 10'($urandom);
    w.offset = 10'($urandom);
    return w;
  endfunction

  // stimulus
  initial begin
    word_t    w;
    outcome_t e;
    ring_t    trial;
    bit       unsafe;
    int       n;
    int       k;
    int       pay;
    logic [7:0] record_bytes [$];

    ring.rd_ptr = '0;
    ring.wr_ptr = '0;
    ring.tent_ptr = '0;
    ring.left = '0;
    ring.rejected = 1'b0;
    for (int i = 0; i < oorr_pkg::BUFFER_BYTES; i++) begin
      ring.mem[i] = '0;
      ring.written[i] = 1'b0;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset state, stray and zero-length bytes, a 6-byte record,
    // reads, offset extremes, a maximum-length record that forces a drop
    add_row(oorr_pkg::ACT_COMMIT, 8'h00, 1'b0, 10'd0, 10'd0, 1'b1, 8'h00, 10'd0, 1'b1);
    add_row(oorr_pkg::ACT_WRITE, 8'hFF, 1'b0, 10'd7, 10'd0, 1'b1, 8'h00, 10'd0, 1'b1);
    add_row(oorr_pkg::ACT_WRITE, 8'h12, 1'b1, 10'd0, 10'd0, 1'b1, 8'h00, 10'd0, 1'b1);
    add_row(oorr_pkg::ACT_WRITE, 8'h00, 1'b1, 10'd6, 10'd0, 1'b1, 8'h00, 10'd1, 1'b0);
    add_row(oorr_pkg::ACT_WRITE, 8'hFF, 1'b0, 10'd0, 10'd0, 1'b1, 8'h00, 10'd2, 1'b0);
    add_row(oorr_pkg::ACT_WRITE, 8'h55, 1'b0, 10'd0, 10'd0, 1'b1, 8'h00, 10'd3, 1'b0);
    add_row(oorr_pkg::ACT_WRITE, 8'h01, 1'b0, 10'd0, 10'd0, 1'b1, 8'h00, 10'd4, 1'b0);
    add_row(oorr_pkg::ACT_WRITE, 8'h00, 1'b0, 10'd0, 10'd0, 1'b1, 8'h00, 10'd5, 1'b0);
    add_row(oorr_pkg::ACT_WRITE, 8'hAA, 1'b0, 10'd0, 10'd0, 1'b1, 8'h00, 10'd6, 1'b0);
    add_row(oorr_pkg::ACT_WRITE, 8'h77, 1'b0, 10'd0, 10'd0, 1'b1, 8'h00, 10'd6, 1'b0);
    add_row(oorr_pkg::ACT_START, 8'h00, 1'b0, 10'd0, 10'd0, 1'b1, 8'h00, 10'd6, 1'b0);
    add_row(oorr_pkg::ACT_NEXT, 8'h00, 1'b0, 10'd0, 10'd0, 1'b1, 8'h00, 10'd6, 1'b0);
    add_row(oorr_pkg::ACT_NEXT, 8'h00, 1'b0, 10'd0, 10'd0, 1'b1, 8'hFF, 10'd6, 1'b0);
    add_row(oorr_pkg::ACT_COMMIT, 8'h00, 1'b0, 10'd0, 10'd0, 1'b1, 8'h00, 10'd4, 1'b0);
    // largest offset twice walks the read pointer back to the record start
    add_row(oorr_pkg::ACT_START, 8'h00, 1'b0, 10'd0, 10'd1023, 1'b0, 8'h00, 10'd0, 1'b0);
    add_row(oorr_pkg::ACT_COMMIT, 8'h00, 1'b0, 10'd0, 10'd0, 1'b0, 8'h00, 10'd0, 1'b0);
    add_row(oorr_pkg::ACT_START, 8'h00, 1'b0, 10'd0, 10'd1023, 1'b0, 8'h00, 10'd0, 1'b0);
    add_row(oorr_pkg::ACT_COMMIT, 8'h00, 1'b0, 10'd0, 10'd0, 1'b0, 8'h00, 10'd0, 1'b0);
    add_row(oorr_pkg::ACT_WRITE, 8'h3C, 1'b1, 10'd1023, 10'd0, 1'b0, 8'h00, 10'd0, 1'b0);
    add_row(oorr_pkg::ACT_WRITE, 8'hC3, 1'b0, 10'd0, 10'd0, 1'b0, 8'h00, 10'd0, 1'b0);
    add_row(oorr_pkg::ACT_WRITE, 8'h00, 1'b1, 10'd1, 10'd0, 1'b0, 8'h00, 10'd0, 1'b0);
    foreach (rows[i]) begin
      ring_step(ring, rows[i].w, e, unsafe);
      send(rows[i].w, rows[i].known ? rows[i].e : e);
    end

    // random: mostly well-formed records, with reads, commits and noise
    n = 0;
    while (n < 1450) begin
      if (n % 150 == 0) no_idle = ($urandom_range(0, 3) == 0);
      k = $urandom_range(0, 99);
      w = '{act: oorr_pkg::ACT_START, data: 8'd0, first: 1'b0, len: 10'd0, offset: 10'd0};
      if (record_bytes.size() != 0 && k < 75) begin
        w.act = oorr_pkg::ACT_WRITE;
        w.data = record_bytes.pop_front();
        w.len = 10'($urandom);
        w.offset = 10'($urandom);
      end else if (k < 82) begin
        // new record; header size field sometimes broken
        pay = ($urandom_range(0, 39) == 0) ? $urandom_range(100, 1018)
                                           : $urandom_range(0, 30);
        record_bytes.delete();
        for (int i = 0; i < oorr_pkg::HEADER_BYTES + pay; i++)
          record_bytes.push_back(8'($urandom));
        if ($urandom_range(0, 9) != 0) begin
          record_bytes[oorr_pkg::SIZE_FIELD_OFFSET] = 8'(pay);
          record_bytes[oorr_pkg::SIZE_FIELD_OFFSET + 1] = 8'(pay >> 8);
        end
        w.act = oorr_pkg::ACT_WRITE;
        w.first = 1'b1;
        w.data = record_bytes.pop_front();
        w.len = ($urandom_range(0, 19) == 0) ? 10'($urandom)
                                             : 10'(oorr_pkg::HEADER_BYTES + pay);
        w.offset = 10'($urandom);
      end else if (k < 88) begin
        w.act = oorr_pkg::ACT_START;
        w.offset = ($urandom_range(0, 2) == 0) ? 10'($urandom) : 10'($urandom_range(0, 8));
        w.data = 8'($urandom);
        w.len = 10'($urandom);
      end else if (k < 94) begin
        w.act = oorr_pkg::ACT_NEXT;
      end else if (k < 97) begin
        w.act = oorr_pkg::ACT_COMMIT;
      end else begin
        w = any_word();
      end
      trial = ring;
      ring_step(trial, w, e, unsafe);
      if (unsafe) begin
        // would touch bytes never written: restart the read instead
        w = '{act: oorr_pkg::ACT_START, data: 8'($urandom), first: 1'($urandom),
              len: 10'd0, offset: 10'd0};
        trial = ring;
        ring_step(trial, w, e, unsafe);
      end
      ring = trial;
      send(w, e);
      n++;
    end
    push <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("** overwrite_oldest_record_ring: PASSED **");
    end else begin
      $display("** overwrite_oldest_record_ring: FAILED **");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/oorr_pkg.sv
hw/rtl/oorr_front.sv
hw/rtl/oorr_back.sv
hw/rtl/overwrite_oldest_record_ring.sv
sim/testbench.sv
